### sv/itoa_pkg.sv
package itoa_pkg;

  // default sizes
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PAD_DIGITS_DEF  = 8;

  // field widths
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 7;
  localparam int DIGIT_W  = 4;

  // format codes carried in the input tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_HEX_LOWER     = 3'd0,
    ACT_HEX_LOWER_PAD = 3'd1,
    ACT_HEX_UPPER     = 3'd2,
    ACT_HEX_UPPER_PAD = 3'd3,
    ACT_DEC           = 3'd4
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  // commands to the digit register
  typedef struct packed {
    logic load_hex;
    logic load_dec;
    logic step;
  } digit_cmd_t;

  // ascii anchors
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_TEN     = 7'd10;

  // one digit (0 to 15) to its ascii code
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (dx < CH_TEN) begin
      digit_char = CH_ZERO + dx;
    end else if (upper) begin
      digit_char = CH_UPPER_A + dx - CH_TEN;
    end else begin
      digit_char = CH_LOWER_A + dx - CH_TEN;
    end
  endfunction

endpackage

### sv/itoa_digits.sv
module itoa_digits #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = 10,
  parameter int IDX_W       = 4
) (
  input  logic                          clk,
  input  itoa_pkg::digit_cmd_t          cmd,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic [itoa_pkg::DIGIT_W-1:0]  rd_digit
);
  import itoa_pkg::*;

  localparam int DIG_BITS = NUM_DIGITS * DIGIT_W;

  logic [VALUE_WIDTH-1:0]                 bin;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]     digits;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]     adj;

  // shift-and-add-3 correction, independent per digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  // digit register: hex load, binary load, or one bcd shift step
  always_ff @(posedge clk) begin
    if (cmd.load_hex) begin
      digits <= DIG_BITS'(value);
    end else if (cmd.load_dec) begin
      digits <= '0;
      bin    <= value;
    end else if (cmd.step) begin
      // corrected digits move up one bit, next binary bit enters at the bottom
      digits <= DIG_BITS'({adj, bin[VALUE_WIDTH-1]});
      bin    <= bin << 1;
    end
  end

  // selected digit for strip and emit
  assign rd_digit = digits[rd_idx];

endmodule

### sv/integer_to_ascii_formatter.sv
// Integer to ASCII formatter. Each input beat carries an unsigned value in tdata and a format
// code in tuser (hex lower, hex lower padded to PAD_DIGITS, hex upper, hex upper padded,
// unsigned decimal); the block returns the text one character per output beat, most
// significant first, with tlast on the final character. Unpadded formats drop leading zeros
// but always give at least one digit; unused format codes are taken and produce nothing.
// One number is handled at a time and the input is not ready until its last character has
// been taken. All digits sit in one register of NUM_DIGITS nibbles (NUM_DIGITS is the largest
// of the decimal width, hex width and PAD_DIGITS; 10 at the default sizes). Hex values load
// straight in; decimal runs a shift-and-add-3 unit over each value bit. Leading zeros are
// then dropped one digit per cycle, and characters leave at one per cycle while the output is
// ready.
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int PAD_DIGITS  = itoa_pkg::PAD_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // value
  input  logic [itoa_pkg::ACTION_W-1:0]      s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // char_code
  output logic                               m_axis_tlast   // last
);
  import itoa_pkg::*;

  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int MAX_DH     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int NUM_DIGITS = (MAX_DH > PAD_DIGITS) ? MAX_DH : PAD_DIGITS;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int BIT_W      = $clog2(VALUE_WIDTH + 1);

  state_t               state, state_next;
  logic [CNT_W-1:0]     n, n_next;
  logic [CNT_W-1:0]     min_digits, min_digits_next;
  logic [BIT_W-1:0]     bitcnt, bitcnt_next;
  logic                 upper, upper_next;
  logic [CNT_W-1:0]     n_dec;
  logic [DIGIT_W-1:0]   cur_digit;
  digit_cmd_t           cmd;
  action_t              action;
  logic                 in_beat;
  logic                 out_beat;
  logic                 strip_more;

  assign action     = action_t'(s_axis_tuser);
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_beat   = m_axis_tvalid && m_axis_tready;
  assign n_dec      = n - CNT_W'(1);
  assign strip_more = (n > min_digits) && (cur_digit == '0);

  // digit register and shift unit
  itoa_digits #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS),
    .IDX_W       (IDX_W)
  ) u_digits (
    .clk      (clk),
    .cmd      (cmd),
    .value    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .rd_idx   (n_dec[IDX_W-1:0]),
    .rd_digit (cur_digit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (action == ACT_DEC) begin
            state_next = ST_CONV;
          end else if (action inside {ACT_HEX_LOWER, ACT_HEX_LOWER_PAD,
                                      ACT_HEX_UPPER, ACT_HEX_UPPER_PAD}) begin
            state_next = ST_STRIP;
          end
        end
      end
      ST_CONV: begin
        if (bitcnt == BIT_W'(1)) state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (!strip_more) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_beat && n == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load_hex  = in_beat && (action inside {ACT_HEX_LOWER, ACT_HEX_LOWER_PAD,
                                                   ACT_HEX_UPPER, ACT_HEX_UPPER_PAD});
        cmd.load_dec  = in_beat && (action == ACT_DEC);
      end
      ST_CONV:  cmd.step      = 1'b1;
      ST_STRIP: ;
      ST_EMIT:  m_axis_tvalid = 1'b1;
      default:  ;
    endcase
  end

  assign m_axis_tdata = {1'b0, digit_char(cur_digit, upper)};
  assign m_axis_tlast = (n == CNT_W'(1));

  // counters and format flags
  always_comb begin
    n_next          = n;
    min_digits_next = min_digits;
    bitcnt_next     = bitcnt;
    upper_next      = upper;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          n_next          = CNT_W'(NUM_DIGITS);
          bitcnt_next     = BIT_W'(VALUE_WIDTH);
          upper_next      = (action == ACT_HEX_UPPER) || (action == ACT_HEX_UPPER_PAD);
          min_digits_next = ((action == ACT_HEX_LOWER_PAD) || (action == ACT_HEX_UPPER_PAD))
                            ? CNT_W'(PAD_DIGITS) : CNT_W'(1);
        end
      end
      ST_CONV:  bitcnt_next = bitcnt - BIT_W'(1);
      ST_STRIP: begin
        if (strip_more) n_next = n_dec;
      end
      ST_EMIT: begin
        if (out_beat) n_next = n_dec;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      n          <= '0;
      min_digits <= CNT_W'(1);
      bitcnt     <= '0;
      upper      <= 1'b0;
    end else begin
      state      <= state_next;
      n          <= n_next;
      min_digits <= min_digits_next;
      bitcnt     <= bitcnt_next;
      upper      <= upper_next;
    end
  end

endmodule
